@@ rtl/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// Types, codes and reset constants shared by the page allocator files.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int NUM_PAGES_DEF = 64;

	localparam int PS_W      = 16;
	localparam int PIU_W     = 7;
	localparam int REQ_W     = 22;
	localparam int PG_W      = 6;
	localparam int CNT_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = PIU_W + PS_W;
	localparam int SUM_W     = REQ_W + 2;

	localparam logic [PS_W-1:0]  PAGE_SIZE_RST = 16'd4096;
	localparam logic [PIU_W-1:0] PAGES_RST     = 7'd64;
	localparam logic [REQ_W-1:0] BYTES_MAX     = 22'h3F_FFFF;

	localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGES_IN_USE = 2'd1;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_GRANTED  = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_FREED    = 2'd2,
		ST_IGNORED  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_MARK,
		S_FREE_CHK,
		S_FREE_CLR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0] run_len;
		logic             used;
	} page_entry_t;

endpackage

@@ rtl/first_fit_page_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// First-fit contiguous page allocator over a page table held in memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the page table clear, one page a cycle, and
// takes no item until that is done. An allocate first checks the free byte
// count, then scans pages from page 0 up to the end of the first run that
// fits (at most min(pages_in_use, NUM_PAGES) pages), then marks the pages of
// that run; a refused request skips the scan. A free reads the start page,
// then releases its pages one by one. Every item then passes its result to
// the output register, and waits while that register still holds a stalled
// result. The single page table port pair and the shared multiplier make
// these steps run one after another. A finished result waits in an output
// register, so the next item can be taken while the previous result is
// still pending.
// ----------------------------------------------------------------------------
module first_fit_page_allocator #(
	parameter int NUM_PAGES = fpa_pkg::NUM_PAGES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fpa_pkg::PS_W-1:0]        cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            action,
	input  logic [fpa_pkg::REQ_W-1:0]       request_bytes,
	input  logic [fpa_pkg::PG_W-1:0]        free_page,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      status,
	output logic [fpa_pkg::PG_W-1:0]        start_page,
	output logic [fpa_pkg::CNT_W-1:0]       page_count,
	output logic [fpa_pkg::REQ_W-1:0]       bytes_used_after
);
	import fpa_pkg::*;

	localparam int PW = $clog2(NUM_PAGES);
	localparam int LW = (PW + 1 > PIU_W) ? PW + 1 : PIU_W;
	localparam logic [LW-1:0] LAST_PAGE = LW'(NUM_PAGES - 1);
	localparam logic [LW-1:0] NPAGES    = LW'(NUM_PAGES);

	state_t state_q, state_d;

	logic [PS_W-1:0]  page_size_q;
	logic [PIU_W-1:0] pages_in_use_q;

	logic [LW-1:0]    idx_q, idx_d;
	logic [LW-1:0]    rd_q, rd_d;
	logic             pend_q, pend_d;
	logic [SUM_W-1:0] sum_q, sum_d;
	logic [LW-1:0]    start_q, start_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [LW-1:0]    limit_q, limit_d;
	logic [LW-1:0]    mark_q, mark_d;
	logic [CNT_W-1:0] rem_q, rem_d;
	logic [REQ_W-1:0] req_q, req_d;
	logic [PG_W-1:0]  fp_q, fp_d;
	logic [REQ_W-1:0] biu_q, biu_d;

	status_t          res_status_q, res_status_d;
	logic [PG_W-1:0]  res_start_q, res_start_d;
	logic [CNT_W-1:0] res_cnt_q, res_cnt_d;

	logic             out_valid_q, out_valid_d;
	status_t          out_status_q, out_status_d;
	logic [PG_W-1:0]  out_start_q, out_start_d;
	logic [CNT_W-1:0] out_cnt_q, out_cnt_d;
	logic [REQ_W-1:0] out_bytes_q, out_bytes_d;

	// page table and multiplier ports
	logic             tbl_we;
	logic [PW-1:0]    tbl_waddr;
	page_entry_t      tbl_wdata;
	logic [PW-1:0]    tbl_raddr;
	page_entry_t      tbl_rdata;
	logic             mac_en;
	logic [PIU_W-1:0] mac_a;
	logic [PROD_W-1:0] mac_p;

	logic [LW-1:0]    limit_cfg;
	logic [SUM_W-1:0] sum_new;
	logic             issue;
	logic [REQ_W+2:0] add_full;
	logic [REQ_W-1:0] biu_add;
	logic [PROD_W-1:0] biu_sub_full;
	logic [REQ_W-1:0] biu_sub;
	logic [SUM_W-1:0] need;

	fpa_table #(.DEPTH(NUM_PAGES), .AW(PW)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	fpa_mac u_mac (
		.clk (clk),
		.en  (mac_en),
		.a   (mac_a),
		.b   (page_size_q),
		.p   (mac_p)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q    <= PAGE_SIZE_RST;
			pages_in_use_q <= PAGES_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PAGE_SIZE:    page_size_q    <= cfg_data;
				REG_PAGES_IN_USE: pages_in_use_q <= cfg_data[PIU_W-1:0];
				default: ;
			endcase
		end
	end

	assign limit_cfg = (LW'(pages_in_use_q) < NPAGES) ? LW'(pages_in_use_q) : NPAGES;
	assign sum_new   = sum_q + SUM_W'(page_size_q);
	assign issue     = idx_q < limit_q;
	assign need      = SUM_W'(biu_q) + SUM_W'(req_q);

	// saturate the byte total both ways
	assign add_full     = (REQ_W+3)'(biu_q) + (REQ_W+3)'(sum_q);
	assign biu_add      = (add_full > (REQ_W+3)'(BYTES_MAX)) ? BYTES_MAX
	                                                         : add_full[REQ_W-1:0];
	assign biu_sub_full = PROD_W'(biu_q) - mac_p;
	assign biu_sub      = (mac_p > PROD_W'(biu_q)) ? '0 : biu_sub_full[REQ_W-1:0];

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		rd_d         = rd_q;
		pend_d       = pend_q;
		sum_d        = sum_q;
		start_d      = start_q;
		cnt_d        = cnt_q;
		limit_d      = limit_q;
		mark_d       = mark_q;
		rem_d        = rem_q;
		req_d        = req_q;
		fp_d         = fp_q;
		biu_d        = biu_q;
		res_status_d = res_status_q;
		res_start_d  = res_start_q;
		res_cnt_d    = res_cnt_q;
		out_valid_d  = out_valid_q;
		out_status_d = out_status_q;
		out_start_d  = out_start_q;
		out_cnt_d    = out_cnt_q;
		out_bytes_d  = out_bytes_q;

		in_ready  = 1'b0;
		tbl_we    = 1'b0;
		tbl_waddr = mark_q[PW-1:0];
		tbl_wdata = '0;
		tbl_raddr = PW'(free_page);
		mac_en    = 1'b0;
		mac_a     = limit_cfg[PIU_W-1:0];

		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			S_CLEAR: begin
				tbl_we = 1'b1;
				mark_d = mark_q + 1'b1;
				if (mark_q == LAST_PAGE) begin
					state_d = S_IDLE;
				end
			end

			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					req_d = request_bytes;
					fp_d  = free_page;
					if (action == ACT_ALLOC) begin
						mac_en  = 1'b1;
						limit_d = limit_cfg;
						state_d = S_CHECK;
					end else if (LW'(free_page) >= NPAGES) begin
						res_status_d = ST_IGNORED;
						res_start_d  = free_page;
						res_cnt_d    = '0;
						state_d      = S_DONE;
					end else begin
						state_d = S_FREE_CHK;
					end
				end
			end

			S_CHECK: begin
				idx_d   = '0;
				pend_d  = 1'b0;
				sum_d   = '0;
				start_d = '0;
				cnt_d   = '0;
				// an empty request always fits the free byte count
				if ((need <= SUM_W'(mac_p) || req_q == '0) && limit_q != '0) begin
					state_d = S_SCAN;
				end else begin
					res_status_d = ST_NO_SPACE;
					res_start_d  = '0;
					res_cnt_d    = '0;
					state_d      = S_DONE;
				end
			end

			S_SCAN: begin
				// read one page ahead, judge the page read last cycle
				tbl_raddr = idx_q[PW-1:0];
				rd_d      = idx_q;
				pend_d    = issue;
				if (issue) begin
					idx_d = idx_q + 1'b1;
				end
				if (pend_q) begin
					if (tbl_rdata.used) begin
						cnt_d   = '0;
						sum_d   = '0;
						start_d = rd_q + 1'b1;
					end else begin
						sum_d = sum_new;
						cnt_d = cnt_q + 1'b1;
						if (sum_new >= SUM_W'(req_q)) begin
							mark_d  = start_q;
							rem_d   = cnt_q + 1'b1;
							state_d = S_MARK;
						end
					end
				end else if (!issue) begin
					res_status_d = ST_NO_SPACE;
					res_start_d  = '0;
					res_cnt_d    = '0;
					state_d      = S_DONE;
				end
			end

			S_MARK: begin
				tbl_we            = 1'b1;
				tbl_wdata.used    = 1'b1;
				tbl_wdata.run_len = (mark_q == start_q) ? cnt_q : '0;
				mark_d            = mark_q + 1'b1;
				rem_d             = rem_q - 1'b1;
				if (rem_q == CNT_W'(1)) begin
					biu_d        = biu_add;
					res_status_d = ST_GRANTED;
					res_start_d  = start_q[PG_W-1:0];
					res_cnt_d    = cnt_q;
					state_d      = S_DONE;
				end
			end

			S_FREE_CHK: begin
				mac_a = tbl_rdata.run_len;
				if (tbl_rdata.run_len == '0) begin
					res_status_d = ST_IGNORED;
					res_start_d  = fp_q;
					res_cnt_d    = '0;
					state_d      = S_DONE;
				end else begin
					mac_en  = 1'b1;
					rem_d   = tbl_rdata.run_len;
					cnt_d   = tbl_rdata.run_len;
					mark_d  = LW'(fp_q);
					state_d = S_FREE_CLR;
				end
			end

			S_FREE_CLR: begin
				// clearing the start page drops its run length as well
				tbl_we = 1'b1;
				mark_d = mark_q + 1'b1;
				rem_d  = rem_q - 1'b1;
				if (rem_q == CNT_W'(1) || mark_q == LAST_PAGE) begin
					biu_d        = biu_sub;
					res_status_d = ST_FREED;
					res_start_d  = fp_q;
					res_cnt_d    = cnt_q;
					state_d      = S_DONE;
				end
			end

			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d  = 1'b1;
					out_status_d = res_status_q;
					out_start_d  = res_start_q;
					out_cnt_d    = res_cnt_q;
					out_bytes_d  = biu_q;
					state_d      = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			mark_q      <= '0;
			pend_q      <= 1'b0;
			biu_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			mark_q      <= mark_d;
			pend_q      <= pend_d;
			biu_q       <= biu_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q        <= idx_d;
		rd_q         <= rd_d;
		sum_q        <= sum_d;
		start_q      <= start_d;
		cnt_q        <= cnt_d;
		limit_q      <= limit_d;
		rem_q        <= rem_d;
		req_q        <= req_d;
		fp_q         <= fp_d;
		res_status_q <= res_status_d;
		res_start_q  <= res_start_d;
		res_cnt_q    <= res_cnt_d;
		out_status_q <= out_status_d;
		out_start_q  <= out_start_d;
		out_cnt_q    <= out_cnt_d;
		out_bytes_q  <= out_bytes_d;
	end

	assign out_valid        = out_valid_q;
	assign status           = out_status_q;
	assign start_page       = out_start_q;
	assign page_count       = out_cnt_q;
	assign bytes_used_after = out_bytes_q;

endmodule

@@ rtl/fpa_table.sv @@
// ----------------------------------------------------------------------------
// fpa_table
// Page table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fpa_table #(
	parameter int DEPTH = fpa_pkg::NUM_PAGES_DEF,
	parameter int AW    = $clog2(fpa_pkg::NUM_PAGES_DEF)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  fpa_pkg::page_entry_t  wdata,
	input  logic [AW-1:0]         raddr,
	output fpa_pkg::page_entry_t  rdata
);
	import fpa_pkg::*;

	page_entry_t mem [DEPTH];
	page_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/fpa_mac.sv @@
// ----------------------------------------------------------------------------
// fpa_mac
// Shared page-count by page-size multiplier with a registered product.
// ----------------------------------------------------------------------------
module fpa_mac (
	input  logic                         clk,
	input  logic                         en,
	input  logic [fpa_pkg::PIU_W-1:0]    a,
	input  logic [fpa_pkg::PS_W-1:0]     b,
	output logic [fpa_pkg::PROD_W-1:0]   p
);
	import fpa_pkg::*;

	logic [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

	assign p = p_q;

endmodule

@@ rtl/fpa_chk.sv @@
// ----------------------------------------------------------------------------
// fpa_chk
// Port-level checks for the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fpa_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [1:0]                    status,
	input logic [fpa_pkg::PG_W-1:0]      start_page,
	input logic [fpa_pkg::CNT_W-1:0]     page_count,
	input logic [fpa_pkg::REQ_W-1:0]     bytes_used_after
);
	import fpa_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(start_page) && $stable(page_count) && $stable(bytes_used_after))
		else $error("result changed while stalled");

	// the sequencer is not ready again in the cycle after it takes an item
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on consecutive cycles");

	a_grant_pages: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_GRANTED || status == ST_FREED) |-> page_count != '0)
		else $error("granted or freed run with no pages");

	a_fail_pages: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NO_SPACE || status == ST_IGNORED) |-> page_count == '0)
		else $error("refused item reports pages");

	a_fail_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NO_SPACE |-> start_page == '0)
		else $error("refused allocation reports a start page");

endmodule

bind first_fit_page_allocator fpa_chk u_fpa_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.status           (status),
	.start_page       (start_page),
	.page_count       (page_count),
	.bytes_used_after (bytes_used_after)
);
